@@ design/dws_pkg.sv @@
// Shared types and codes for the deque with search.
// No dependencies; the cell and the top level take names from here.
package dws_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // The operation that every cell carries out
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_TAKE_FRONT = 2'd1,
    CELL_TAKE_BACK  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     search;
    logic     take;
  } cell_ctl_t;

endpackage

@@ design/dws_cell.sv @@
// One storage cell of the deque: holds an entry, shifts with its neighbors,
// loads a new word at the back and compares against the search key.
// Depends on dws_pkg.
module dws_cell (
  input  logic                             clk,
  input  dws_pkg::cell_ctl_t               ctl,
  input  logic                             load,
  input  logic                             live,
  input  logic signed [dws_pkg::VAL_W-1:0] key,
  input  logic signed [dws_pkg::VAL_W-1:0] front_val,
  input  logic signed [dws_pkg::VAL_W-1:0] back_val,
  output logic signed [dws_pkg::VAL_W-1:0] val,
  output logic                             match
);

  logic signed [dws_pkg::VAL_W-1:0] val_r;
  logic signed [dws_pkg::VAL_W-1:0] val_nxt;
  logic                             match_r;
  logic                             match_nxt;

  // pick the next entry: hold, load, or take from a neighbor
  always_comb begin
    unique case (ctl.op)
      dws_pkg::CELL_HOLD:       val_nxt = load ? key : val_r;
      dws_pkg::CELL_TAKE_FRONT: val_nxt = front_val;
      dws_pkg::CELL_TAKE_BACK:  val_nxt = back_val;
      default:                  val_nxt = val_r;
    endcase
    match_nxt = ctl.search && live && (val_r == key);
  end

  // entry and match flag carry no reset
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctl.take) begin
      match_r <= match_nxt;
    end
  end

  assign val   = val_r;
  assign match = match_r;

endmodule

@@ design/deque_with_search.sv @@
// A result is registered and valid in the cycle after its request word is accepted.
// Throughput: one request per cycle while the result side takes each word;
//   the single output register holds off input while its word is stalled.
// Every cell shifts or compares in the same cycle, all in parallel across the row.
// Reset clears the occupancy and the output valid; entry contents stay
//   undefined until written, and no clearing pass runs.
module deque_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dws_pkg::MODE_W-1:0]            in_mode,
  input  logic signed [dws_pkg::VAL_W-1:0]      in_item_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dws_pkg::STAT_W-1:0]            out_status,
  output logic                                  out_found,
  output logic [dws_pkg::COUNT_W-1:0]           out_entry_count
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]                 occ_r;
  logic [CNT_W-1:0]                 occ_nxt;
  dws_pkg::status_t                 st_r;
  dws_pkg::status_t                 st_nxt;
  logic                             out_valid_r;
  logic                             out_valid_nxt;
  logic                             acc;
  logic                             full;
  logic                             empty;
  logic                             push_back_en;
  dws_pkg::mode_t                   mode;
  dws_pkg::cell_ctl_t               ctl;
  logic signed [dws_pkg::VAL_W-1:0] vals [DEPTH];
  logic [DEPTH-1:0]                 hits;

  assign acc   = in_valid && !in_stall;
  assign full  = (occ_r == CNT_W'(DEPTH));
  assign empty = (occ_r == '0);
  assign mode  = dws_pkg::mode_t'(in_mode);

  // decode the request into a cell command and the new occupancy
  always_comb begin
    ctl.op       = dws_pkg::CELL_HOLD;
    ctl.search   = 1'b0;
    ctl.take     = acc;
    push_back_en = 1'b0;
    st_nxt       = dws_pkg::ST_OK;
    occ_nxt      = occ_r;
    if (acc) begin
      unique case (mode)
        dws_pkg::MODE_PUSH_FRONT: begin
          if (full) begin
            st_nxt = dws_pkg::ST_FULL;
          end else begin
            ctl.op  = dws_pkg::CELL_TAKE_FRONT;
            occ_nxt = occ_r + CNT_W'(1);
          end
        end
        dws_pkg::MODE_PUSH_BACK: begin
          if (full) begin
            st_nxt = dws_pkg::ST_FULL;
          end else begin
            push_back_en = 1'b1;
            occ_nxt      = occ_r + CNT_W'(1);
          end
        end
        dws_pkg::MODE_POP_FRONT: begin
          if (empty) begin
            st_nxt = dws_pkg::ST_EMPTY;
          end else begin
            ctl.op  = dws_pkg::CELL_TAKE_BACK;
            occ_nxt = occ_r - CNT_W'(1);
          end
        end
        dws_pkg::MODE_POP_BACK: begin
          if (empty) begin
            st_nxt = dws_pkg::ST_EMPTY;
          end else begin
            occ_nxt = occ_r - CNT_W'(1);
          end
        end
        dws_pkg::MODE_SEARCH: ctl.search = 1'b1;
        default: ;
      endcase
    end
  end

  // row of cells; the key enters at the front and caps the back end
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic signed [dws_pkg::VAL_W-1:0] front_val;
    logic signed [dws_pkg::VAL_W-1:0] back_val;

    if (k == 0) begin : g_first
      assign front_val = in_item_value;
    end else begin : g_mid_front
      assign front_val = vals[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign back_val = in_item_value;
    end else begin : g_mid_back
      assign back_val = vals[k+1];
    end

    dws_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .load      (push_back_en && (occ_r == CNT_W'(k))),
      .live      (occ_r > CNT_W'(k)),
      .key       (in_item_value),
      .front_val (front_val),
      .back_val  (back_val),
      .val       (vals[k]),
      .match     (hits[k])
    );
  end

  // hold the result word until it is taken
  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (acc) begin
      st_r <= st_nxt;
    end
  end

  assign in_stall        = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_status      = st_r;
  assign out_found       = |hits;
  assign out_entry_count = dws_pkg::COUNT_W'(occ_r);

  // occupancy never exceeds the row length
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  // a full flag only when the row is full
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (st_r == dws_pkg::ST_FULL) |-> full)
    else $error("full status with free cells");

  // an empty flag only when nothing is held
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (st_r == dws_pkg::ST_EMPTY) |-> empty)
    else $error("empty status with held entries");

  // a good push at the back grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (mode == dws_pkg::MODE_PUSH_BACK) && !full |=> occ_r == $past(occ_r) + CNT_W'(1))
    else $error("push did not grow occupancy");

  // a match flag only follows a search
  a_found_search: assert property (@(posedge clk) disable iff (!rst_n)
    acc && (mode != dws_pkg::MODE_SEARCH) |=> !out_found)
    else $error("found set outside a search");

endmodule
